/* src/set_assoc_cache_tag_lookup_assert.svh */
// Assertion macros for the set-associative cache tag lookup
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
// antecedent implies consequent on the next edge
`define SACT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// condition holds on every edge
`define SACT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

/* src/sact_pkg.sv */
// Shared types and constants of the cache tag lookup
`timescale 1ns / 1ps
package sact_pkg;
    localparam int CNT_BITS = 48;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    localparam logic [2:0] CFG_OFFSET = 3'd0;
    localparam logic [2:0] CFG_INDEX  = 3'd1;
    localparam logic [2:0] CFG_WAYS   = 3'd2;
    localparam logic [2:0] CFG_POLICY = 3'd3;
    localparam logic [2:0] CFG_SEED   = 3'd4;

    localparam logic [1:0] POL_PLRU = 2'd0;
    localparam logic [1:0] POL_FIFO = 2'd1;

    typedef struct packed {
        logic clear;
        logic lookup;
        logic update;
        logic emit;
    } sact_cmd_t;

    typedef struct packed {
        logic clear_done;
    } sact_status_t;
endpackage

/* src/sact_ctrl.sv */
// Control state machine of the cache tag lookup
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_assert.svh"
module sact_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  out_busy,
    input  sact_pkg::sact_status_t status,
    output sact_pkg::sact_cmd_t   cmd,
    output logic                  in_ready
);
    import sact_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clear_done) state_next = ST_IDLE;
            ST_IDLE:   if (in_fire) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_EMIT;
            ST_EMIT:   if (!out_busy) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.update = (state_reg == ST_UPDATE);
    assign cmd.emit   = (state_reg == ST_EMIT) && !out_busy;

    `SACT_ASSERT_ALWAYS(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `SACT_ASSERT_NEXT(a_lookup_upd, clk, rst_n, cmd.lookup, cmd.update, "lookup not followed by update")
    `SACT_ASSERT_NEXT(a_accept, clk, rst_n, in_fire, cmd.lookup, "accepted beat not looked up")
endmodule

/* src/sact_datapath.sv */
// Datapath of the cache tag lookup: tag store, replacement state, counters
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_assert.svh"
module sact_datapath #(
    parameter int ADDR_BITS = 32,
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sact_pkg::sact_cmd_t   cmd,
    output sact_pkg::sact_status_t status,
    input  logic                  in_fire,
    input  logic [ADDR_BITS-1:0]  address,
    input  logic                  cfg_fire,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output logic                  res_hit,
    output logic [2:0]            res_way,
    output logic [sact_pkg::CNT_BITS-1:0] res_access,
    output logic [sact_pkg::CNT_BITS-1:0] res_hits
);
    import sact_pkg::*;

    localparam int WB_MAX = (MAX_WAYS > 1) ? $clog2(MAX_WAYS + 1) - 1 : 0;
    localparam int IB_MAX = (MAX_SETS > 1) ? $clog2(MAX_SETS + 1) - 1 : 0;
    localparam int NW     = 1 << WB_MAX;
    localparam int NS     = 1 << IB_MAX;
    localparam int WW     = (WB_MAX > 0) ? WB_MAX : 1;
    localparam int SW     = (IB_MAX > 0) ? IB_MAX : 1;
    localparam int TW     = (NW > 1) ? NW - 1 : 1;
    localparam int SH_W   = 7;

    logic [4:0]  off_reg;
    logic [3:0]  ib_reg;
    logic [1:0]  wb_reg;
    logic [1:0]  pol_reg;
    logic [15:0] lfsr_reg, lfsr_next;

    logic [SW-1:0]        set_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [WW:0]          wbe;
    logic [WW-1:0]        wmask;

    logic [NW-1:0]        valid_reg [NS];
    logic [ADDR_BITS-1:0] tag_mem   [NS][NW];
    logic [ADDR_BITS-1:0] rd_tag    [NW];
    logic [NW-1:0]        rd_valid;
    logic [TW-1:0]        plru_reg  [NS];
    logic [WW-1:0]        fifo_reg  [NS];
    logic [TW-1:0]        rd_tree_reg;
    logic [WW-1:0]        rd_fifo_reg;
    logic [SW:0]          clr_cnt_reg;

    logic                 hit_c;
    logic [WW-1:0]        hway_c, vic_c, used_c;
    logic [TW-1:0]        tree_c;
    logic [CNT_BITS-1:0]  acc_reg, hits_reg;

    assign wbe   = (wb_reg > 2'(WB_MAX)) ? (WW+1)'(WB_MAX) : (WW+1)'(wb_reg);
    assign wmask = WW'(((WW+1)'(1) << wbe) - (WW+1)'(1));
    assign status.clear_done = clr_cnt_reg[SW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= 5'd2;
            ib_reg   <= 4'd4;
            wb_reg   <= 2'd2;
            pol_reg  <= POL_PLRU;
            lfsr_reg <= 16'd1;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_OFFSET: off_reg <= cfg_data[4:0];
                    CFG_INDEX:  ib_reg  <= cfg_data[3:0];
                    CFG_WAYS:   wb_reg  <= cfg_data[1:0];
                    CFG_POLICY: pol_reg <= cfg_data[1:0];
                    CFG_SEED:   lfsr_reg <= (cfg_data == 16'd0) ? 16'd1 : cfg_data;
                    default: ;
                endcase
            end
            else if (cmd.update && !hit_c && pol_reg[1])
            begin
                lfsr_reg <= lfsr_next;
            end
        end
    end

    assign lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5], lfsr_reg[15:1]};

    // split the address on accept
    logic [3:0]  ibe;
    logic [SH_W-1:0] sh;
    assign ibe = (ib_reg > 4'(IB_MAX)) ? 4'(IB_MAX) : ib_reg;
    assign sh  = SH_W'(off_reg) + SH_W'(ibe);

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            set_reg  <= SW'((address >> off_reg) & ((ADDR_BITS)'(1) << ibe) - ADDR_BITS'(1));
            tag_reg  <= (sh >= SH_W'(ADDR_BITS)) ? '0 : (address >> sh);
        end
    end

    // registered read of the selected set
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            for (int w = 0; w < NW; w++)
            begin
                rd_tag[w] <= tag_mem[set_reg][w];
            end
            rd_tree_reg <= plru_reg[set_reg];
            rd_fifo_reg <= fifo_reg[set_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid <= '0;
        end
        else if (cmd.lookup)
        begin
            rd_valid <= valid_reg[set_reg];
        end
    end

    always_comb
    begin
        hit_c  = 1'b0;
        hway_c = '0;
        for (int w = NW - 1; w >= 0; w--)
        begin
            if (rd_valid[w] && rd_tag[w] == tag_reg && WW'(w) <= wmask)
            begin
                hit_c  = 1'b1;
                hway_c = WW'(w);
            end
        end
    end

    // tree PLRU touch or victim walk, at most three levels
    always_comb
    begin
        int node;
        logic b;
        tree_c = rd_tree_reg;
        vic_c  = '0;
        node   = 0;
        b      = 1'b0;
        for (int i = 0; i < WB_MAX; i++)
        begin
            if (i < int'(wbe))
            begin
                if (hit_c)
                begin
                    b = hway_c[int'(wbe) - 1 - i];
                    tree_c[node] = ~b;
                end
                else
                begin
                    b = tree_c[node];
                    tree_c[node] = ~b;
                    vic_c = WW'({vic_c, b});
                end
                node = node * 2 + 1 + int'(b);
            end
        end
    end

    always_comb
    begin
        if (hit_c)
            used_c = hway_c;
        else if (pol_reg[1])
            used_c = lfsr_next[WW-1:0] & wmask;
        else if (pol_reg == POL_FIFO)
            used_c = rd_fifo_reg & wmask;
        else
            used_c = vic_c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && !hit_c)
        begin
            tag_mem[set_reg][used_c] <= tag_reg;
        end
    end

    // set state: one set cleared per cycle after reset, then one set written per access
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            valid_reg[clr_cnt_reg[SW-1:0]] <= '0;
            plru_reg[clr_cnt_reg[SW-1:0]]  <= '0;
            fifo_reg[clr_cnt_reg[SW-1:0]]  <= '0;
        end
        else if (cmd.update)
        begin
            if (!hit_c) valid_reg[set_reg][used_c] <= 1'b1;
            if (pol_reg == POL_PLRU) plru_reg[set_reg] <= tree_c;
            if (!hit_c && pol_reg == POL_FIFO)
                fifo_reg[set_reg] <= (used_c + 1'b1) & wmask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            acc_reg     <= '0;
            hits_reg    <= '0;
            res_hit     <= 1'b0;
            res_way     <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.update)
            begin
                res_hit <= hit_c;
                res_way <= 3'(used_c);
                if (acc_reg != CNT_MAX) acc_reg <= acc_reg + 1'b1;
                if (hit_c && hits_reg != CNT_MAX) hits_reg <= hits_reg + 1'b1;
            end
        end
    end

    assign res_access = acc_reg;
    assign res_hits   = hits_reg;

    `SACT_ASSERT_NEXT(a_fill_valid, clk, rst_n, cmd.update && !hit_c, valid_reg[$past(set_reg)][$past(used_c)], "filled way not valid")
    `SACT_ASSERT_NEXT(a_acc_mono, clk, rst_n, cmd.update, acc_reg != '0, "access count did not advance")
    `SACT_ASSERT_ALWAYS(a_hits_le, clk, rst_n, hits_reg <= acc_reg, "hits exceed accesses")
endmodule

/* src/set_assoc_cache_tag_lookup.sv */
// Top level of the set-associative cache tag lookup
//  channel | dir | payload
//  s_axis  | in  | tdata: address
//  m_axis  | out | tdata: hit, way, accesses, hits
//  cfg     | in  | index 0..4, data
// An access passes through accept, set read, compare and update, and result.
// The set read and the read-modify-write of the set state limit the rate.
// After reset a clear pass over the sets runs before s_axis_tready rises.
// A stalled result holds the block in its output state until taken.
`timescale 1ns / 1ps
module set_assoc_cache_tag_lookup #(
    parameter int ADDR_BITS = 32,
    parameter int MAX_WAYS  = 8,
    parameter int MAX_SETS  = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [ADDR_BITS-1:0] s_axis_tdata,   // address
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [103:0]         m_axis_tdata,   // hit, way[2:0], accesses, hits
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import sact_pkg::*;

    sact_cmd_t    cmd;
    sact_status_t status;
    logic         in_fire, res_hit, out_busy;
    logic [2:0]   res_way;
    logic [CNT_BITS-1:0] res_access, res_hits;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_axis_tvalid <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            m_axis_tdata <= {4'd0, res_hits, res_access, res_way, res_hit};
        end
    end

    assign out_busy = m_axis_tvalid && !m_axis_tready;

    sact_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_busy(out_busy),
        .status(status), .cmd(cmd), .in_ready(s_axis_tready)
    );

    sact_datapath #(.ADDR_BITS(ADDR_BITS), .MAX_WAYS(MAX_WAYS), .MAX_SETS(MAX_SETS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_fire(in_fire), .address(s_axis_tdata),
        .cfg_fire(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .res_hit(res_hit), .res_way(res_way), .res_access(res_access), .res_hits(res_hits)
    );
endmodule
